// ----- design/white_balance_gain_gamma_stage_unit_assert.svh -----
// Assertion macros shared by the white balance and gamma modules.
`ifndef WHITE_BALANCE_GAIN_GAMMA_STAGE_UNIT_ASSERT_SVH
`define WHITE_BALANCE_GAIN_GAMMA_STAGE_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define WBG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define WBG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/wbg_pkg.sv -----
// Shared types, constants and gamma table helpers for the white balance stage.
package wbg_pkg;

    localparam int SampleBits   = 16;
    localparam int GainFracBits = 16;
    localparam int GainBits     = 23;
    localparam int RomDepth     = 1 << SampleBits;
    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = GainBits;

    localparam logic [SampleBits-1:0] SampleMaxVal = '1;

    // Gamma 2.2 as an exact integer test: y^GammaDen <= n^GammaNum * max^(GammaDen-GammaNum)
    localparam int GammaNum  = 5;
    localparam int GammaDen  = 11;
    localparam int WideBits  = GammaDen * SampleBits + 1;

    typedef logic [WideBits-1:0] t_wide;
    typedef t_wide t_a_diffs [GammaDen+1];
    typedef t_wide t_b_diffs [GammaNum+1];

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_GAIN_RED   = 3'd0,
        CFG_GAIN_GREEN = 3'd1,
        CFG_GAIN_BLUE  = 3'd2,
        CFG_CLIP_RED   = 3'd3,
        CFG_CLIP_GREEN = 3'd4,
        CFG_CLIP_BLUE  = 3'd5,
        CFG_GAMMA_EN   = 3'd6
    } t_cfg_index;

    // One table write from the fill engine
    typedef struct packed {
        logic                  we;
        logic [SampleBits-1:0] addr;
        logic [SampleBits-1:0] data;
    } t_fill_wr;

    function automatic t_wide f_pow(input t_wide base, input int e);
        t_wide acc;
        acc = t_wide'(1);
        for (int i = 0; i < e; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // Forward differences of (y+1)^GammaDen at y = 0
    function automatic t_a_diffs f_a_diffs();
        t_a_diffs vals;
        t_a_diffs res;
        for (int i = 0; i <= GammaDen; i++) begin
            vals[i] = f_pow(t_wide'(i + 1), GammaDen);
        end
        for (int k = 0; k <= GammaDen; k++) begin
            res[k] = vals[0];
            for (int i = 0; i < GammaDen - k; i++) begin
                vals[i] = vals[i+1] - vals[i];
            end
        end
        return res;
    endfunction

    // Forward differences of n^GammaNum * max^(GammaDen-GammaNum) at n = 0
    function automatic t_b_diffs f_b_diffs();
        t_b_diffs vals;
        t_b_diffs res;
        t_wide    scale;
        scale = f_pow(t_wide'(SampleMaxVal), GammaDen - GammaNum);
        for (int i = 0; i <= GammaNum; i++) begin
            vals[i] = f_pow(t_wide'(i), GammaNum) * scale;
        end
        for (int k = 0; k <= GammaNum; k++) begin
            res[k] = vals[0];
            for (int i = 0; i < GammaNum - k; i++) begin
                vals[i] = vals[i+1] - vals[i];
            end
        end
        return res;
    endfunction

endpackage

// ----- design/white_balance_gain_gamma_stage_unit.sv -----
// Throughput: one pixel per clock while o_stall is low; four pipeline steps (clip, multiply,
// saturate with table read, output queue), the gamma table read being a registered RAM read.
// Results appear at the output queue head (o_valid).
// Reset: the gamma table is rebuilt by the fill engine, one table step a cycle;
// o_stall stays high until the fill is done. Register writes are taken throughout.
module white_balance_gain_gamma_stage_unit import wbg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CfgIndexBits-1:0] i_cfg_index,
    input  logic [CfgDataBits-1:0]  i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SampleBits-1:0]   i_red_in,
    input  logic [SampleBits-1:0]   i_green_in,
    input  logic [SampleBits-1:0]   i_blue_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SampleBits-1:0]   o_red_out,
    output logic [SampleBits-1:0]   o_green_out,
    output logic [SampleBits-1:0]   o_blue_out
);

    localparam int Lanes     = 3;
    localparam int ProdBits  = SampleBits + GainBits;
    localparam int ShiftBits = ProdBits - GainFracBits;
    localparam int OutDepth  = 8;
    localparam int PtrBits   = $clog2(OutDepth) + 1;

    typedef logic [SampleBits-1:0] t_sample;

    // configuration
    logic [GainBits-1:0] r_gain [Lanes];
    t_sample             r_clip [Lanes];
    logic                r_gamma_en;

    // pipeline
    t_sample             w_in   [Lanes];
    t_sample             w_clip [Lanes];
    logic                r_v1, r_v2, r_v3;
    t_sample             r_s1   [Lanes];
    logic [ProdBits-1:0] r_prod [Lanes];
    logic [ShiftBits-1:0] w_shift [Lanes];
    t_sample             w_lin  [Lanes];
    t_sample             r_lin3 [Lanes];
    t_sample             w_gam  [Lanes];
    t_sample             w_res  [Lanes];

    // output queue and request credit
    t_sample             r_fifo [OutDepth][Lanes];
    logic [PtrBits-1:0]  r_wptr, r_rptr;
    logic [PtrBits-1:0]  w_fifo_cnt;
    logic [PtrBits-1:0]  r_total, n_total;
    logic [PtrBits-1:0]  w_inflight;
    logic                r_stall, n_stall;
    logic                w_acc, w_pop;

    t_fill_wr            w_fill;
    logic                w_fill_done;

    wbg_gamma_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (w_fill),
        .o_done  (w_fill_done)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < Lanes; c++) begin
                r_gain[c] <= GainBits'(1 << GainFracBits);
                r_clip[c] <= SampleMaxVal;
            end
            r_gamma_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_GAIN_RED:   r_gain[0]  <= i_cfg_data[GainBits-1:0];
                CFG_GAIN_GREEN: r_gain[1]  <= i_cfg_data[GainBits-1:0];
                CFG_GAIN_BLUE:  r_gain[2]  <= i_cfg_data[GainBits-1:0];
                CFG_CLIP_RED:   r_clip[0]  <= i_cfg_data[SampleBits-1:0];
                CFG_CLIP_GREEN: r_clip[1]  <= i_cfg_data[SampleBits-1:0];
                CFG_CLIP_BLUE:  r_clip[2]  <= i_cfg_data[SampleBits-1:0];
                CFG_GAMMA_EN:   r_gamma_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_acc = i_valid && !r_stall;
    assign w_pop = o_valid && !i_stall;

    always_comb begin
        w_in[0] = i_red_in;
        w_in[1] = i_green_in;
        w_in[2] = i_blue_in;
        for (int c = 0; c < Lanes; c++) begin
            w_clip[c]  = (w_in[c] > r_clip[c]) ? r_clip[c] : w_in[c];
            w_shift[c] = r_prod[c][ProdBits-1:GainFracBits];
            w_lin[c]   = (|w_shift[c][ShiftBits-1:SampleBits]) ? SampleMaxVal
                                                               : w_shift[c][SampleBits-1:0];
            w_res[c]   = r_gamma_en ? w_gam[c] : r_lin3[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        for (int c = 0; c < Lanes; c++) begin
            r_s1[c]   <= w_clip[c];
            r_prod[c] <= ProdBits'(r_s1[c]) * ProdBits'(r_gain[c]);
            r_lin3[c] <= w_lin[c];
        end
    end

    // one copy of the gamma table per lane, all filled together
    for (genvar c = 0; c < Lanes; c++) begin : g_lane
        wbg_ram #(
            .Width (SampleBits),
            .Depth (RomDepth)
        ) u_gamma_ram (
            .i_clk   (i_clk),
            .i_we    (w_fill.we),
            .i_waddr (w_fill.addr),
            .i_wdata (w_fill.data),
            .i_re    (r_v2),
            .i_raddr (w_lin[c]),
            .o_rdata (w_gam[c])
        );
    end

    assign w_fifo_cnt = r_wptr - r_rptr;
    assign n_total    = r_total + PtrBits'(w_acc) - PtrBits'(w_pop);
    // registered stall: every accepted request already holds a queue slot
    assign n_stall    = !w_fill_done || (n_total >= PtrBits'(OutDepth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_total <= '0;
            r_stall <= 1'b1;
        end else begin
            if (r_v3) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_total <= n_total;
            r_stall <= n_stall;
        end
        if (r_v3) begin
            for (int c = 0; c < Lanes; c++) begin
                r_fifo[r_wptr[PtrBits-2:0]][c] <= w_res[c];
            end
        end
    end

    assign o_stall     = r_stall;
    assign o_valid     = (r_wptr != r_rptr);
    assign o_red_out   = r_fifo[r_rptr[PtrBits-2:0]][0];
    assign o_green_out = r_fifo[r_rptr[PtrBits-2:0]][1];
    assign o_blue_out  = r_fifo[r_rptr[PtrBits-2:0]][2];

    assign w_inflight = PtrBits'(r_v1) + PtrBits'(r_v2) + PtrBits'(r_v3) + w_fifo_cnt;

`include "white_balance_gain_gamma_stage_unit_assert.svh"

    `WBG_ASSERT(a_no_accept_in_fill, !w_fill_done |-> r_stall, "request open during table fill")
    `WBG_ASSERT(a_credit_match, r_total == w_inflight, "credit count out of step")
    `WBG_ASSERT(a_queue_bound, r_total <= PtrBits'(OutDepth), "output queue overrun")
    `WBG_ASSERT(a_out_after_fill, o_valid |-> w_fill_done, "result before table fill end")

endmodule

// ----- design/wbg_ram.sv -----
// Generic simple dual port RAM with registered read.
module wbg_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/wbg_gamma_fill.sv -----
// Gamma table fill engine: walks n and y together using forward differences.
module wbg_gamma_fill import wbg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    output t_fill_wr o_wr,
    output logic     o_done
);

    localparam t_a_diffs AInit = f_a_diffs();
    localparam t_b_diffs BInit = f_b_diffs();

    // r_a[0] = (y+1)^11, r_b[0] = n^5 * max^6, higher entries their differences
    t_wide                 r_a [GammaDen];
    t_wide                 r_b [GammaNum];
    logic [SampleBits-1:0] r_n;
    logic [SampleBits-1:0] r_y;
    logic                  r_done;
    logic                  w_take_y;

    assign w_take_y = !r_done && (r_y != SampleMaxVal) && (r_a[0] <= r_b[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_n    <= '0;
            r_y    <= '0;
            for (int k = 0; k < GammaDen; k++) begin
                r_a[k] <= AInit[k];
            end
            for (int k = 0; k < GammaNum; k++) begin
                r_b[k] <= BInit[k];
            end
        end else if (!r_done) begin
            if (w_take_y) begin
                r_y <= r_y + 1'b1;
                for (int k = 0; k < GammaDen - 1; k++) begin
                    r_a[k] <= r_a[k] + r_a[k+1];
                end
                r_a[GammaDen-1] <= r_a[GammaDen-1] + AInit[GammaDen];
            end else begin
                r_n <= r_n + 1'b1;
                if (r_n == SampleMaxVal) begin
                    r_done <= 1'b1;
                end
                for (int k = 0; k < GammaNum - 1; k++) begin
                    r_b[k] <= r_b[k] + r_b[k+1];
                end
                r_b[GammaNum-1] <= r_b[GammaNum-1] + BInit[GammaNum];
            end
        end
    end

    always_comb begin
        o_wr.we   = !r_done && !w_take_y;
        o_wr.addr = r_n;
        o_wr.data = r_y;
    end

    assign o_done = r_done;

`include "white_balance_gain_gamma_stage_unit_assert.svh"

    `WBG_ASSERT(a_fill_quiet_when_done, r_done |-> !o_wr.we, "table write after fill end")
    `WBG_ASSERT_NEXT(a_fill_y_step, w_take_y, r_y == $past(r_y) + 1'b1, "y did not advance")
    `WBG_ASSERT_NEXT(a_fill_last, o_wr.we && (r_n == SampleMaxVal), r_done, "fill not closed")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the white balance, gain and gamma pixel stage.
module tb_top;
    import wbg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 1000000;
    localparam int SettleCycles = 8;
    localparam int PhaseItems   = 67;
    localparam int RandPhases   = 6;
    localparam int MaxReports   = 10;
    localparam int PowBits      = GammaDen * SampleBits + 1;

    // index 7 decodes to no register
    localparam logic [CfgIndexBits-1:0] CfgIndexSpare = 3'd7;

    typedef struct {
        logic [SampleBits-1:0] red;
        logic [SampleBits-1:0] green;
        logic [SampleBits-1:0] blue;
    } t_rgb_px;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic [CfgIndexBits-1:0] cfg_index = '0;
    logic [CfgDataBits-1:0]  cfg_data  = '0;
    logic                    o_cfg_ready;

    logic                  px_valid = 1'b0;
    logic [SampleBits-1:0] px_red   = '0;
    logic [SampleBits-1:0] px_green = '0;
    logic [SampleBits-1:0] px_blue  = '0;
    logic                  o_stall;

    logic                  o_valid;
    logic                  sink_stall = 1'b0;
    logic [SampleBits-1:0] o_red_out;
    logic [SampleBits-1:0] o_green_out;
    logic [SampleBits-1:0] o_blue_out;

    // predictor state
    logic [SampleBits-1:0] gamma_lut [RomDepth];
    logic [GainBits-1:0]   gain_cfg [3];
    logic [SampleBits-1:0] clip_cfg [3];
    logic                  gamma_cfg;

    t_rgb_px pending_px[$];
    t_rgb_px expected_px[$];

    int items_queued = 0;
    int results_done = 0;
    int err_count    = 0;
    int cycle_count  = 0;
    int src_gap      = 0;
    int sink_hold    = 0;
    bit src_calm     = 1'b0;
    bit sink_calm    = 1'b0;

    white_balance_gain_gamma_stage_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (px_valid),
        .o_stall     (o_stall),
        .i_red_in    (px_red),
        .i_green_in  (px_green),
        .i_blue_in   (px_blue),
        .o_valid     (o_valid),
        .i_stall     (sink_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    always #5 clk = ~clk;

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MaxReports) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Largest y with y^11 <= n^5 * max^6; y never falls as n grows.
    function automatic void build_gamma_lut();
        logic [PowBits-1:0] scale;
        logic [PowBits-1:0] bound;
        logic [PowBits-1:0] next_pow;
        logic [PowBits-1:0] base;
        int unsigned        y;
        scale = PowBits'(1);
        for (int k = 0; k < GammaDen - GammaNum; k++) begin
            scale = scale * PowBits'(SampleMaxVal);
        end
        y        = 0;
        next_pow = PowBits'(1);
        for (int n = 0; n < RomDepth; n++) begin
            base  = PowBits'(n);
            bound = scale;
            for (int k = 0; k < GammaNum; k++) begin
                bound = bound * base;
            end
            while (y < SampleMaxVal && next_pow <= bound) begin
                y++;
                base     = PowBits'(y + 1);
                next_pow = PowBits'(1);
                for (int k = 0; k < GammaDen; k++) begin
                    next_pow = next_pow * base;
                end
            end
            gamma_lut[n] = SampleBits'(y);
        end
    endfunction

    function automatic logic [SampleBits-1:0] grade_channel(
        input logic [SampleBits-1:0] sample,
        input logic [SampleBits-1:0] clip,
        input logic [GainBits-1:0]   gain
    );
        logic [SampleBits-1:0]          limited;
        logic [SampleBits+GainBits-1:0] product;
        logic [GainBits-1:0]            scaled;
        logic [SampleBits-1:0]          linear;
        limited = (sample > clip) ? clip : sample;
        product = limited * gain;
        scaled  = GainBits'(product >> GainFracBits);
        linear  = ((scaled >> SampleBits) != 0) ? SampleMaxVal : scaled[SampleBits-1:0];
        return gamma_cfg ? gamma_lut[linear] : linear;
    endfunction

    function automatic t_rgb_px grade_pixel(input logic [SampleBits-1:0] r,
                                            input logic [SampleBits-1:0] g,
                                            input logic [SampleBits-1:0] b);
        t_rgb_px px;
        px.red   = grade_channel(r, clip_cfg[0], gain_cfg[0]);
        px.green = grade_channel(g, clip_cfg[1], gain_cfg[1]);
        px.blue  = grade_channel(b, clip_cfg[2], gain_cfg[2]);
        return px;
    endfunction

    function automatic logic [SampleBits-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SampleMaxVal;
            2: return SampleBits'($urandom_range(0, 255));
            3: return SampleBits'($urandom_range(65280, 65535));
            default: return SampleBits'($urandom);
        endcase
    endfunction

    function automatic logic [CfgDataBits-1:0] rand_gain();
        case ($urandom_range(0, 6))
            0: return CfgDataBits'(65536);
            1: return CfgDataBits'($urandom_range(7, 6553600));
            2: return CfgDataBits'($urandom);
            3: return CfgDataBits'(7);
            4: return CfgDataBits'(6553600);
            default: return CfgDataBits'($urandom_range(32768, 131072));
        endcase
    endfunction

    // upper data bits are noise for the narrow registers
    function automatic logic [CfgDataBits-1:0] rand_clip();
        case ($urandom_range(0, 4))
            0: return CfgDataBits'(SampleMaxVal);
            1: return '0;
            2: return CfgDataBits'($urandom);
            default: return CfgDataBits'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                             input logic [CfgDataBits-1:0]  data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (o_cfg_ready !== 1'b1) @(posedge clk);
        case (idx)
            CFG_GAIN_RED:   gain_cfg[0] = data;
            CFG_GAIN_GREEN: gain_cfg[1] = data;
            CFG_GAIN_BLUE:  gain_cfg[2] = data;
            CFG_CLIP_RED:   clip_cfg[0] = data[SampleBits-1:0];
            CFG_CLIP_GREEN: clip_cfg[1] = data[SampleBits-1:0];
            CFG_CLIP_BLUE:  clip_cfg[2] = data[SampleBits-1:0];
            CFG_GAMMA_EN:   gamma_cfg   = data[0];
            default: ;
        endcase
    endtask

    task automatic add_px(input logic [SampleBits-1:0] r,
                          input logic [SampleBits-1:0] g,
                          input logic [SampleBits-1:0] b);
        pending_px.push_back('{r, g, b});
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_done != items_queued) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic add_edge_pixels();
        add_px('0, '0, '0);
        add_px(SampleMaxVal, SampleMaxVal, SampleMaxVal);
        add_px(16'h0001, 16'h8000, 16'h7FFF);
        add_px(16'hAAAA, 16'h5555, 16'hFFFE);
        add_px(16'h5555, 16'hAAAA, 16'h8001);
    endtask

    // source side: one request per pending pixel, random gap between requests unless src_calm
    always @(posedge clk) begin
        t_rgb_px nxt;
        logic    held;
        if (px_valid && o_stall === 1'b0) begin
            expected_px.push_back(grade_pixel(px_red, px_green, px_blue));
        end
        held = px_valid && o_stall !== 1'b0;
        if (!held && src_gap > 0) begin
            src_gap--;
            px_valid <= 1'b0;
        end else if (!held && pending_px.size() > 0) begin
            nxt      = pending_px.pop_front();
            px_valid <= 1'b1;
            px_red   <= nxt.red;
            px_green <= nxt.green;
            px_blue  <= nxt.blue;
            src_gap  = src_calm ? 0 : $urandom_range(0, 6);
        end else if (!held) begin
            px_valid <= 1'b0;
        end
    end

    // sink side: check each result request, then hold off for a random spell unless sink_calm
    always @(posedge clk) begin
        t_rgb_px want;
        if (o_valid === 1'b1 && !sink_stall) begin
            if (expected_px.size() == 0) begin
                note_error($sformatf("unexpected result r=%h g=%h b=%h",
                                     o_red_out, o_green_out, o_blue_out));
            end else begin
                want = expected_px.pop_front();
                results_done++;
                if (o_red_out !== want.red)
                    note_error($sformatf("red: expected %h, got %h", want.red, o_red_out));
                if (o_green_out !== want.green)
                    note_error($sformatf("green: expected %h, got %h", want.green, o_green_out));
                if (o_blue_out !== want.blue)
                    note_error($sformatf("blue: expected %h, got %h", want.blue, o_blue_out));
            end
            sink_hold = sink_calm ? 0 : $urandom_range(0, 6);
        end
        if (sink_hold > 0) begin
            sink_stall <= 1'b1;
            sink_hold--;
        end else begin
            sink_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        build_gamma_lut();
        gain_cfg  = '{CfgDataBits'(65536), CfgDataBits'(65536), CfgDataBits'(65536)};
        clip_cfg  = '{SampleMaxVal, SampleMaxVal, SampleMaxVal};
        gamma_cfg = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: unity gain, open clips, linear
        add_edge_pixels();
        wait_drained();

        // saturating, minimum and zero gains; zero clip; gamma on
        write_reg(CFG_GAIN_RED, CfgDataBits'(6553600));
        write_reg(CFG_GAIN_GREEN, CfgDataBits'(7));
        write_reg(CFG_GAIN_BLUE, '0);
        write_reg(CFG_CLIP_RED, CfgDataBits'(SampleMaxVal));
        write_reg(CFG_CLIP_GREEN, '0);
        write_reg(CFG_CLIP_BLUE, CfgDataBits'(16'h8000));
        write_reg(CFG_GAMMA_EN, CfgDataBits'(1));
        write_reg(CfgIndexSpare, '1);
        cfg_valid <= 1'b0;
        add_edge_pixels();
        add_px(16'h8001, 16'hFFFF, 16'h7FFF);
        wait_drained();

        // largest raw gain, gain just under one, gain of two, clips off the end; junk above gamma bit
        write_reg(CFG_GAIN_RED, '1);
        write_reg(CFG_GAIN_GREEN, CfgDataBits'(65535));
        write_reg(CFG_GAIN_BLUE, CfgDataBits'(131072));
        write_reg(CFG_CLIP_RED, CfgDataBits'(1000));
        write_reg(CFG_CLIP_GREEN, CfgDataBits'(23'h7F0000) | CfgDataBits'(SampleMaxVal));
        write_reg(CFG_CLIP_BLUE, CfgDataBits'(65534));
        write_reg(CFG_GAMMA_EN, CfgDataBits'(23'h7FFFFE));
        cfg_valid <= 1'b0;
        add_edge_pixels();
        wait_drained();

        // both ends of the gamma curve at unity gain
        write_reg(CFG_GAIN_RED, CfgDataBits'(65536));
        write_reg(CFG_GAIN_GREEN, CfgDataBits'(65536));
        write_reg(CFG_GAIN_BLUE, CfgDataBits'(65536));
        write_reg(CFG_CLIP_RED, CfgDataBits'(SampleMaxVal));
        write_reg(CFG_CLIP_GREEN, CfgDataBits'(SampleMaxVal));
        write_reg(CFG_GAMMA_EN, CfgDataBits'(1));
        cfg_valid <= 1'b0;
        add_px('0, 16'h0001, 16'h0002);
        add_px(16'h0003, 16'h0010, 16'h0100);
        add_px(16'hFFFE, SampleMaxVal, 16'hFFFD);
        add_px(16'h1000, 16'h4000, 16'hC000);
        wait_drained();

        for (int phase = 0; phase < RandPhases; phase++) begin
            write_reg(CFG_GAIN_RED, rand_gain());
            write_reg(CFG_GAIN_GREEN, rand_gain());
            write_reg(CFG_GAIN_BLUE, rand_gain());
            write_reg(CFG_CLIP_RED, rand_clip());
            write_reg(CFG_CLIP_GREEN, rand_clip());
            write_reg(CFG_CLIP_BLUE, rand_clip());
            write_reg(CFG_GAMMA_EN, ($urandom_range(0, 3) == 0) ? CfgDataBits'($urandom)
                                                              : CfgDataBits'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CfgIndexSpare, CfgDataBits'($urandom));
            end
            cfg_valid <= 1'b0;
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PhaseItems; k++) begin
                add_px(rand_sample(), rand_sample(), rand_sample());
            end
            wait_drained();
        end

        if (expected_px.size() != 0) begin
            note_error($sformatf("%0d results never arrived", expected_px.size()));
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
